// File: src/heartbeat_fault_monitor_top_macros.svh
// Assertion macros for the heartbeat fault monitor.
// No dependencies; included by the top level.
`ifndef HEARTBEAT_FAULT_MONITOR_TOP_MACROS_SVH
`define HEARTBEAT_FAULT_MONITOR_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HFM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HFM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/hfm_pkg.sv
// Shared types and constants of the heartbeat fault monitor.
// No dependencies; imported by every module of the block.
package hfm_pkg;

    localparam int NUM_MODULES = 16;
    localparam int SLOTS       = (NUM_MODULES < 16) ? NUM_MODULES : 16;
    localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam int MODULE_ID_W = 4;
    localparam int CODE_W      = 16;
    localparam int AGE_W       = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [1:0] OP_LIFE  = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_CHECK = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_ENABLED_MASK  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_TICKS = CFG_INDEX_W'(1);

    localparam logic [15:0]      MASK_RESET    = 16'h0DFE;
    localparam logic [15:0]      TIMEOUT_RESET = 16'd500;
    localparam logic [AGE_W-1:0] AGE_MAX       = '1;

    typedef struct packed {
        logic [1:0]             op;
        logic [MODULE_ID_W-1:0] sender_id;
        logic                   fault_flag;
        logic [CODE_W-1:0]      life_code;
    } t_in_item;

    typedef struct packed {
        logic                   any_fault;
        logic                   has_entry;
        logic [MODULE_ID_W-1:0] faulty_module;
        logic [CODE_W:0]        reported_code;
        logic                   timed_out;
        logic                   last;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic life_write;
        logic tick;
        logic scan_start;
        logic scan_step;
        logic emit_final;
    } t_ctrl_cmd;

    typedef struct packed {
        logic hit;
        logic pend_valid;
        logic out_free;
        logic idx_end;
    } t_dp_status;

endpackage

// File: src/hfm_ctrl.sv
// Controller state machine of the heartbeat fault monitor.
// Depends on hfm_pkg; drives hfm_dp through t_ctrl_cmd.
module hfm_ctrl
    import hfm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_op,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    case (i_op)
                        OP_LIFE:  o_cmd.life_write = 1'b1;
                        OP_TICK:  o_cmd.tick       = 1'b1;
                        OP_CHECK: begin
                            o_cmd.scan_start = 1'b1;
                            n_state          = ST_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                // hold the slot while a found entry cannot displace the pending one
                if (!(i_status.hit && i_status.pend_valid && !i_status.out_free)) begin
                    o_cmd.scan_step = 1'b1;
                    if (i_status.idx_end) begin
                        n_state = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (i_status.out_free) begin
                    o_cmd.emit_final = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// File: src/hfm_dp.sv
// Datapath of the heartbeat fault monitor: slot store, scan and output register.
// Depends on hfm_pkg; commanded by hfm_ctrl.
module hfm_dp
    import hfm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    input  t_in_item               i_item,
    input  t_ctrl_cmd              i_cmd,
    output t_dp_status             o_status,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output t_out_item              o_out_item
);

    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);

    logic [15:0]       r_mask;
    logic [15:0]       r_timeout;
    logic [AGE_W-1:0]  r_age   [SLOTS];
    logic              r_fault [SLOTS];
    logic [CODE_W-1:0] r_code  [SLOTS];
    logic [SLOT_W-1:0] r_idx;
    logic              r_pend_valid;
    t_out_item         r_pend;
    logic              r_out_valid;
    t_out_item         r_out;

    logic [SLOTS-1:0]  w_mask_slots;
    logic              w_late;
    logic              w_hit;
    logic              w_out_free;
    logic              w_life_ok;
    logic [SLOT_W-1:0] w_wr_idx;
    t_out_item         w_cur;
    t_out_item         w_final;

    assign w_mask_slots = r_mask[SLOTS-1:0];
    assign w_late       = r_age[r_idx] > r_timeout;
    assign w_hit        = w_mask_slots[r_idx] && (r_fault[r_idx] || w_late);
    assign w_out_free   = !r_out_valid || i_out_ready;

    // only ids that have a slot and are enabled are stored
    assign w_life_ok = ({1'b0, i_item.sender_id} < (MODULE_ID_W + 1)'(SLOTS))
                       && r_mask[i_item.sender_id];
    assign w_wr_idx  = i_item.sender_id[SLOT_W-1:0];

    always_comb begin
        w_cur               = '0;
        w_cur.any_fault     = 1'b1;
        w_cur.has_entry     = 1'b1;
        w_cur.faulty_module = MODULE_ID_W'(r_idx);
        w_cur.reported_code = {1'b0, r_code[r_idx]} + (CODE_W + 1)'(w_late);
        w_cur.timed_out     = w_late;
        w_cur.last          = 1'b0;

        if (r_pend_valid) begin
            w_final      = r_pend;
            w_final.last = 1'b1;
        end else begin
            w_final      = '0;
            w_final.last = 1'b1;
        end
    end

    assign o_status.hit        = w_hit;
    assign o_status.pend_valid = r_pend_valid;
    assign o_status.out_free   = w_out_free;
    assign o_status.idx_end    = (r_idx == LAST_IDX);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask    <= MASK_RESET;
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ENABLED_MASK:  r_mask    <= i_cfg_wdata;
                REG_TIMEOUT_TICKS: r_timeout <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // slot store: life signals write one slot, ticks age all of them
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_age[i]   <= AGE_MAX;
                r_fault[i] <= 1'b0;
                r_code[i]  <= '0;
            end
        end else if (i_cmd.life_write && w_life_ok) begin
            r_age[w_wr_idx]   <= '0;
            r_fault[w_wr_idx] <= i_item.fault_flag;
            r_code[w_wr_idx]  <= i_item.life_code;
        end else if (i_cmd.tick) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (r_age[i] != AGE_MAX) begin
                    r_age[i] <= r_age[i] + 1'b1;
                end
            end
        end
    end

    // scan pointer and pending entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx        <= '0;
            r_pend_valid <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_idx        <= '0;
            r_pend_valid <= 1'b0;
        end else if (i_cmd.scan_step) begin
            if (r_idx != LAST_IDX) begin
                r_idx <= r_idx + 1'b1;
            end
            if (w_hit) begin
                r_pend_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step && w_hit) begin
            r_pend <= w_cur;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((i_cmd.scan_step && w_hit && r_pend_valid) || i_cmd.emit_final) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step && w_hit && r_pend_valid) begin
            r_out <= r_pend;
        end else if (i_cmd.emit_final) begin
            r_out <= w_final;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// File: src/heartbeat_fault_monitor_top.sv
// Top level of the heartbeat fault monitor.
// Depends on hfm_pkg, hfm_ctrl, hfm_dp and heartbeat_fault_monitor_top_macros.svh.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_item) carries one op per
//   transaction: a life signal, a tick or a fault check. Life signals and
//   ticks take effect in the cycle they are accepted; the next transaction
//   may follow in the very next cycle.
//   A check walks the slots one per cycle through the datapath's single slot
//   read port, holding on a hit while the output stalls and a result is pending,
//   then flushes its final result. It yields one result per faulty or timed-out
//   enabled module, in id order, or one empty result; the final result carries
//   last. Input is not accepted during a check.
//   Output channel (o_out_valid / i_out_ready / o_out_item) is driven from a
//   register; each entry result passes through the pending stage into the
//   output register. When the receiver stalls, the scan holds on the next hit while
//   one result waits in the output register and one in the pending stage.
//   Configuration: i_cfg_we writes i_cfg_wdata to register i_cfg_index
//   (0 enabled mask, 1 timeout in ticks) at once; write only while idle.
//   Reset (synchronous, active low) restores the register defaults, sets all
//   ages to saturated, clears fault bits and codes, and drops any result.
`include "heartbeat_fault_monitor_top_macros.svh"

module heartbeat_fault_monitor_top
    import hfm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  t_in_item               i_in_item,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output t_out_item              o_out_item
);

    t_ctrl_cmd  w_cmd;
    t_dp_status w_status;

    // sequence ops and hold the scan against output back-pressure
    hfm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_in_item.op),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // slot store, per-slot compare, pending stage and output register
    hfm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (i_in_item),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // a check keeps the input closed while it scans
    `HFM_ASSERT_NEXT(a_check_busy, i_clk, i_rst_n, i_in_valid && o_in_ready && i_in_item.op == OP_CHECK, !o_in_ready, "input reopened straight after a check")

    // an empty report is always the final result of its check
    `HFM_ASSERT_SAME(a_empty_is_last, i_clk, i_rst_n, o_out_valid && !o_out_item.has_entry, o_out_item.last && !o_out_item.any_fault, "empty report without last")

    // a timed-out entry always describes a module
    `HFM_ASSERT_SAME(a_timeout_has_entry, i_clk, i_rst_n, o_out_valid && o_out_item.timed_out, o_out_item.has_entry && o_out_item.any_fault, "timeout flagged on empty report")

endmodule

// File: test/heartbeat_fault_monitor_checker.sv
// Scoreboard for the heartbeat fault monitor: mirrors the slot state and the registers.
// Depends on hfm_pkg; instantiated by the testbench beside the block.
module heartbeat_fault_monitor_checker
    import hfm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    input  t_in_item               i_in_item,
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    input  t_out_item              i_out_item,
    output int                     o_pending,
    output int                     o_failures
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [CFG_DATA_W-1:0] mask_r;
    logic [CFG_DATA_W-1:0] timeout_r;
    logic [AGE_W-1:0]      age_r  [SLOTS];
    logic                  fault_r[SLOTS];
    logic [CODE_W-1:0]     code_r [SLOTS];
    t_out_item             report_q[$];
    int                    fail_cnt = 0;

    initial begin
        o_pending  = 0;
        o_failures = 0;
    end

    task automatic clear_watchdog;
        mask_r    = MASK_RESET;
        timeout_r = TIMEOUT_RESET;
        for (int i = 0; i < SLOTS; i++) begin
            age_r[i]   = AGE_MAX;
            fault_r[i] = 1'b0;
            code_r[i]  = '0;
        end
        report_q.delete();
    endtask

    // Update the slot mirror for one transaction and queue the reports it causes.
    task automatic advance_watchdog(input t_in_item it);
        t_out_item rep;
        logic      late_v[SLOTS];
        logic      hit_v [SLOTS];
        int        last_idx;
        last_idx = -1;
        case (it.op)
            OP_LIFE: begin
                if (int'(it.sender_id) < SLOTS && mask_r[it.sender_id]) begin
                    fault_r[it.sender_id] = it.fault_flag;
                    code_r[it.sender_id]  = it.life_code;
                    age_r[it.sender_id]   = '0;
                end
            end
            OP_TICK: begin
                for (int i = 0; i < SLOTS; i++)
                    if (age_r[i] != AGE_MAX) age_r[i] = age_r[i] + 1'b1;
            end
            OP_CHECK: begin
                for (int i = 0; i < SLOTS; i++) begin
                    late_v[i] = age_r[i] > timeout_r;
                    hit_v[i]  = mask_r[i] && (fault_r[i] || late_v[i]);
                    if (hit_v[i]) last_idx = i;
                end
                if (last_idx < 0) begin
                    rep      = '0;
                    rep.last = 1'b1;
                    report_q.insert(report_q.size(), rep);
                end else begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (hit_v[i]) begin
                            rep.any_fault     = 1'b1;
                            rep.has_entry     = 1'b1;
                            rep.faulty_module = MODULE_ID_W'(i);
                            rep.reported_code = {1'b0, code_r[i]} + (CODE_W+1)'(late_v[i]);
                            rep.timed_out     = late_v[i];
                            rep.last          = (i == last_idx);
                            report_q.insert(report_q.size(), rep);
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string field, input logic [CODE_W:0] want,
                               input logic [CODE_W:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            fail_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            clear_watchdog();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_ENABLED_MASK) mask_r = i_cfg_wdata;
                else if (i_cfg_index == REG_TIMEOUT_TICKS) timeout_r = i_cfg_wdata;
            end
            if (i_in_valid && i_in_ready) advance_watchdog(i_in_item);
            if (i_out_valid && i_out_ready) begin
                if (report_q.size() == 0) begin
                    $display("%0t: unexpected report, expected none, actual %h",
                             $time, i_out_item);
                    fail_cnt++;
                end else begin
                    want = report_q.pop_front();
                    check_field("any_fault", want.any_fault, i_out_item.any_fault);
                    check_field("has_entry", want.has_entry, i_out_item.has_entry);
                    check_field("faulty_module", want.faulty_module, i_out_item.faulty_module);
                    check_field("reported_code", want.reported_code, i_out_item.reported_code);
                    check_field("timed_out", want.timed_out, i_out_item.timed_out);
                    check_field("last", want.last, i_out_item.last);
                end
            end
        end
        o_pending  <= report_q.size();
        o_failures <= fail_cnt;
    end

endmodule

// File: test/testbench.sv
// Top of the heartbeat fault monitor testbench: clock, reset, stimulus and verdict.
// Depends on hfm_pkg, heartbeat_fault_monitor_top and heartbeat_fault_monitor_checker.
module testbench;
    import hfm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 40;
    localparam int PHASES          = 7;
    localparam int ITEMS_PER_PHASE = 21;

    // Op and register codes the package leaves unnamed; the block must ignore them.
    localparam logic [1:0]             OP_SPARE    = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = CFG_INDEX_W'(3);

    logic                   i_clk     = 1'b0;
    logic                   i_rst_n   = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   in_valid  = 1'b0;
    t_in_item               in_item   = '0;
    logic                   out_ready = 1'b0;
    logic                   in_ready;
    logic                   out_valid;
    t_out_item              out_item;
    int                     pending;
    int                     failures;

    // Shared with the receiver process; written only with nonblocking assignments.
    bit idle_on     = 1'b1;
    int hold_asked  = 0;
    int hold_served = 0;

    heartbeat_fault_monitor_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    heartbeat_fault_monitor_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_item  (out_item),
        .o_pending   (pending),
        .o_failures  (failures)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Guard against a hung handshake: end the run once the cycle budget is spent.
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("FAILED: results differ");
        $finish;
    end

    // Receiver: random stalls while idling is on, and one long hold-off on request
    // so that a check backs up and the block stops taking input.
    initial begin : receiver
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_asked != hold_served) begin
                out_ready <= 1'b0;
                for (n = 0; n < HOLD_CYCLES; n++) @(posedge i_clk);
                hold_served <= hold_served + 1;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(0, 8)) @(posedge i_clk);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    function automatic t_in_item pack_item(input logic [1:0] op, input logic [3:0] id,
                                           input logic flag, input logic [15:0] code);
        t_in_item it;
        it.op         = op;
        it.sender_id  = id;
        it.fault_flag = flag;
        it.life_code  = code;
        return it;
    endfunction

    // Mostly life signals from enabled ids and ticks, some checks, a little noise.
    function automatic t_in_item random_item(input logic [CFG_DATA_W-1:0] mask);
        t_in_item it;
        int       r;
        r             = $urandom_range(0, 99);
        it.sender_id  = MODULE_ID_W'($urandom());
        it.fault_flag = ($urandom_range(0, 3) == 0);
        it.life_code  = ($urandom_range(0, 7) == 0) ? 16'hFFFF : CODE_W'($urandom());
        if (r < 40) begin
            it.op = OP_LIFE;
            // Steer most life signals to a monitored id.
            if (mask != '0 && $urandom_range(0, 3) != 0)
                while (!mask[it.sender_id]) it.sender_id = it.sender_id + 1'b1;
        end else if (r < 80) begin
            it.op = OP_TICK;
        end else if (r < 95) begin
            it.op = OP_CHECK;
        end else begin
            it.op = OP_SPARE;
        end
        return it;
    endfunction

    // Offer one transaction, after an optional idle burst, and hold it until accepted.
    // Valid stays high on return so back-to-back transactions need no extra step.
    task automatic offer(input t_in_item it);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge i_clk); while (!in_ready);
    endtask

    // Drop valid, wait for every queued report, then let the block drain.
    task automatic quiesce;
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    initial begin : stimulus
        int                    ph;
        int                    k;
        logic [CFG_DATA_W-1:0] mask;
        logic [CFG_DATA_W-1:0] tmo;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset defaults: never-heard slots are saturated, so every enabled id times out.
        offer(pack_item(OP_CHECK, 4'd0, 1'b0, 16'h0000));
        // Id 0 and id 15 are not monitored after reset: their life signals are dropped, ids 1 and 2 are stored.
        offer(pack_item(OP_LIFE, 4'd0, 1'b1, 16'hFFFF));
        offer(pack_item(OP_LIFE, 4'd1, 1'b1, 16'hFFFF));
        offer(pack_item(OP_LIFE, 4'd2, 1'b0, 16'h0000));
        offer(pack_item(OP_LIFE, 4'd15, 1'b1, 16'hAAAA));
        // Unused op with every other field set: no effect, no report.
        offer(pack_item(OP_SPARE, 4'd15, 1'b1, 16'hFFFF));
        offer(pack_item(OP_TICK, 4'd9, 1'b1, 16'h1234));
        offer(pack_item(OP_CHECK, 4'd0, 1'b0, 16'h0000));

        // Zero timeout with every id monitored: one tick is enough to time out.
        quiesce();
        write_reg(REG_ENABLED_MASK, 16'hFFFF);
        write_reg(REG_TIMEOUT_TICKS, 16'h0000);
        offer(pack_item(OP_LIFE, 4'd0, 1'b0, 16'h5555));
        offer(pack_item(OP_LIFE, 4'd15, 1'b1, 16'hFFFF));
        offer(pack_item(OP_CHECK, 4'd0, 1'b0, 16'h0000));
        offer(pack_item(OP_TICK, 4'd0, 1'b0, 16'h0000));
        // Id 15 now carries the code past 16 bits.
        offer(pack_item(OP_CHECK, 4'd0, 1'b0, 16'h0000));

        // Maximum timeout: saturated slots stay quiet, only fault bits report.
        quiesce();
        write_reg(REG_TIMEOUT_TICKS, 16'hFFFF);
        offer(pack_item(OP_CHECK, 4'd0, 1'b0, 16'h0000));

        // Nothing monitored: the check gives the empty report; slot contents survive.
        quiesce();
        write_reg(REG_ENABLED_MASK, 16'h0000);
        offer(pack_item(OP_CHECK, 4'd0, 1'b0, 16'h0000));
        offer(pack_item(OP_LIFE, 4'd3, 1'b1, 16'h0F0F));

        quiesce();
        write_reg(REG_ENABLED_MASK, 16'h0001);
        offer(pack_item(OP_CHECK, 4'd0, 1'b0, 16'h0000));
        offer(pack_item(OP_LIFE, 4'd0, 1'b1, 16'h8001));
        offer(pack_item(OP_CHECK, 4'd0, 1'b0, 16'h0000));

        // Random phases, each under its own register setting.
        for (ph = 0; ph < PHASES; ph++) begin
            quiesce();
            case (ph)
                0: begin
                    mask = CFG_DATA_W'($urandom());
                    tmo  = 16'd3;
                end
                1: begin
                    mask = '1;
                    tmo  = '0;
                end
                2: begin
                    mask = '1;
                    tmo  = 16'd2;
                end
                3: begin
                    mask = '0;
                    tmo  = '1;
                end
                4: begin
                    mask = CFG_DATA_W'($urandom());
                    tmo  = CFG_DATA_W'($urandom_range(0, 15));
                end
                default: begin
                    mask = CFG_DATA_W'($urandom());
                    tmo  = CFG_DATA_W'($urandom_range(1, 8));
                end
            endcase
            // Keep the closing phase free of idling on both sides.
            if (ph == PHASES - 1) idle_on <= 1'b0;
            write_reg(REG_ENABLED_MASK, mask);
            write_reg(REG_TIMEOUT_TICKS, tmo);
            if (ph == 4) begin
                write_reg(REG_SPARE_A, CFG_DATA_W'($urandom()));
                write_reg(REG_SPARE_B, CFG_DATA_W'($urandom()));
            end
            if (ph == 2) begin
                // Long receiver hold-off against a full check; keep offering meanwhile.
                hold_asked <= hold_asked + 1;
                offer(pack_item(OP_CHECK, 4'd0, 1'b0, 16'h0000));
            end
            for (k = 0; k < ITEMS_PER_PHASE; k++) offer(random_item(mask));
        end

        quiesce();
        if (failures == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: files.f
+incdir+src
src/hfm_pkg.sv
src/hfm_ctrl.sv
src/hfm_dp.sv
src/heartbeat_fault_monitor_top.sv
test/heartbeat_fault_monitor_checker.sv
test/testbench.sv
